>>> sv/cbse_pkg.sv
// ----------------------------------------------------------------------------
// cbse_pkg: shared types and constants for the battery state estimator
// Field widths, item structs, register indexes and state codes.
// ----------------------------------------------------------------------------
package cbse_pkg;

  // Voltage field width in millivolts
  localparam int MV_BITS  = 13;
  localparam int RES_BITS = 16;
  localparam int CUR_BITS = 16;
  // Numerator prog_mv * 1000 needs ten more bits than a voltage
  localparam int NUM_W    = MV_BITS + 10;
  localparam int CNT_W    = $clog2(NUM_W + 1);
  localparam int IDX_W    = 3;
  localparam int CFG_W    = RES_BITS;

  localparam logic [NUM_W-1:0]    CUR_SCALE = NUM_W'(1000);
  localparam logic [RES_BITS-1:0] RES_ALL1  = '1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_RES         = 3'd0;
  localparam logic [IDX_W-1:0] REG_CC_MIN      = 3'd1;
  localparam logic [IDX_W-1:0] REG_CV_MIN      = 3'd2;
  localparam logic [IDX_W-1:0] REG_CC_MAX      = 3'd3;
  localparam logic [IDX_W-1:0] REG_FLOAT_MAX   = 3'd4;
  localparam logic [IDX_W-1:0] REG_FULL_MIN    = 3'd5;
  localparam logic [IDX_W-1:0] REG_RECHARGE    = 3'd6;
  localparam logic [IDX_W-1:0] REG_EMPTY_MIN   = 3'd7;

  // Pin modes
  localparam logic [1:0] PIN_INPUT   = 2'd0;
  localparam logic [1:0] PIN_OUTPUT  = 2'd1;
  localparam logic [1:0] PIN_PULLUP  = 2'd2;
  localparam logic [1:0] PIN_INVALID = 2'd3;

  // Current status
  localparam logic [1:0] ST_MEASURED = 2'd0;
  localparam logic [1:0] ST_UNKNOWN  = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;

  // Charger states
  localparam logic [2:0] CHG_ERROR   = 3'd0;
  localparam logic [2:0] CHG_UNKNOWN = 3'd1;
  localparam logic [2:0] CHG_CC      = 3'd2;
  localparam logic [2:0] CHG_CV      = 3'd3;
  localparam logic [2:0] CHG_FLOAT   = 3'd4;
  localparam logic [2:0] CHG_OFF     = 3'd5;

  // Battery states
  localparam logic [2:0] BAT_ERROR    = 3'd0;
  localparam logic [2:0] BAT_CHARGING = 3'd1;
  localparam logic [2:0] BAT_FULL     = 3'd2;
  localparam logic [2:0] BAT_EMPTY    = 3'd3;
  localparam logic [2:0] BAT_IDLE     = 3'd4;
  localparam logic [2:0] BAT_UNKNOWN  = 3'd5;

  typedef struct packed {
    logic [MV_BITS-1:0] supply_mv;
    logic               supply_ok;
    logic [MV_BITS-1:0] prog_mv;
    logic               prog_ok;
    logic [1:0]         pin_mode;
    logic               pin_level;
  } in_item_t;

  typedef struct packed {
    logic                sample_valid;
    logic [CUR_BITS-1:0] current_ma;
    logic [1:0]          current_status;
    logic [2:0]          charger_state;
    logic [2:0]          battery_state;
    logic                battery_low;
    logic                battery_full;
  } out_item_t;

  typedef struct packed {
    logic [RES_BITS-1:0] rprog_ohms;
    logic [MV_BITS-1:0]  prog_cc_min_mv;
    logic [MV_BITS-1:0]  prog_cv_min_mv;
    logic [MV_BITS-1:0]  prog_cc_max_mv;
    logic [MV_BITS-1:0]  prog_float_max_mv;
    logic [MV_BITS-1:0]  full_supply_min_mv;
    logic [MV_BITS-1:0]  recharge_min_mv;
    logic [MV_BITS-1:0]  empty_supply_min_mv;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    rprog_ohms:          RES_BITS'(5000),
    prog_cc_min_mv:      MV_BITS'(900),
    prog_cv_min_mv:      MV_BITS'(100),
    prog_cc_max_mv:      MV_BITS'(1100),
    prog_float_max_mv:   MV_BITS'(10),
    full_supply_min_mv:  MV_BITS'(4200),
    recharge_min_mv:     MV_BITS'(4050),
    empty_supply_min_mv: MV_BITS'(3300)
  };

  // Held state pair going into the evaluator
  typedef struct packed {
    logic [2:0] charger;
    logic [2:0] battery;
  } held_t;

endpackage

>>> sv/cbse_if.sv
// ----------------------------------------------------------------------------
// cbse_if: valid/ready channels for measurement and result items
// One interface per direction, each with source and sink modports.
// ----------------------------------------------------------------------------
interface cbse_in_if;
  import cbse_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cbse_out_if;
  import cbse_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/charger_battery_state_estimator.sv
// ----------------------------------------------------------------------------
// charger_battery_state_estimator: charge current and charger/battery state
// Sequence: an accepted item that needs a current division goes through the divide
//   and finish states, any other item straight to finish; the result is registered.
// Flow: one item at a time; the serial divider makes one quotient bit per cycle,
//   and a new item is accepted only after the result enters the output register,
//   so a result that waits for the output to drain also holds off the input.
// Reset: registers return to their documented values, held states unknown,
//   no result pending.
// ----------------------------------------------------------------------------
module charger_battery_state_estimator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cbse_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [cbse_pkg::CFG_W-1:0]    cfg_wdata_i,
  cbse_in_if.sink                       in_ch,
  cbse_out_if.source                    out_ch
);
  import cbse_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  cfg_t             cfg_q;
  in_item_t         item_q;
  logic [1:0]       status_q;
  logic             div_used_q;
  held_t            held_q;
  logic             out_valid_q;
  out_item_t        out_data_q;

  logic             accept;
  logic [1:0]       status_in;
  logic             div_in;
  logic             load;
  logic             div_done;
  logic [NUM_W-1:0] quot;
  logic [NUM_W-1:0] numer;
  out_item_t        result;
  held_t            held_next;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RES:       cfg_q.rprog_ohms          <= cfg_wdata_i[RES_BITS-1:0];
        REG_CC_MIN:    cfg_q.prog_cc_min_mv      <= cfg_wdata_i[MV_BITS-1:0];
        REG_CV_MIN:    cfg_q.prog_cv_min_mv      <= cfg_wdata_i[MV_BITS-1:0];
        REG_CC_MAX:    cfg_q.prog_cc_max_mv      <= cfg_wdata_i[MV_BITS-1:0];
        REG_FLOAT_MAX: cfg_q.prog_float_max_mv   <= cfg_wdata_i[MV_BITS-1:0];
        REG_FULL_MIN:  cfg_q.full_supply_min_mv  <= cfg_wdata_i[MV_BITS-1:0];
        REG_RECHARGE:  cfg_q.recharge_min_mv     <= cfg_wdata_i[MV_BITS-1:0];
        REG_EMPTY_MIN: cfg_q.empty_supply_min_mv <= cfg_wdata_i[MV_BITS-1:0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  assign in_ch.ready = (state_q == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Current status from the incoming item; division only inside the window
  always_comb begin
    status_in = ST_MEASURED;
    div_in    = 1'b0;
    if (!in_ch.data.prog_ok || cfg_q.rprog_ohms == '0 ||
        cfg_q.rprog_ohms == RES_ALL1 || in_ch.data.pin_mode == PIN_INVALID) begin
      status_in = ST_INVALID;
    end else if (in_ch.data.pin_mode == PIN_OUTPUT) begin
      status_in = in_ch.data.pin_level ? ST_MEASURED : ST_UNKNOWN;
    end else if (in_ch.data.pin_mode == PIN_PULLUP) begin
      status_in = ST_UNKNOWN;
    end else begin
      div_in = (in_ch.data.prog_mv <= cfg_q.prog_cc_max_mv) &&
               (in_ch.data.prog_mv >= cfg_q.prog_float_max_mv);
    end
  end

  assign numer = NUM_W'(in_ch.data.prog_mv) * CUR_SCALE;

  cbse_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && div_in),
    .num_i   (numer),
    .div_i   (cfg_q.rprog_ohms),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= in_ch.data;
      status_q   <= status_in;
      div_used_q <= div_in;
    end
  end

  cbse_eval u_eval (
    .item_i     (item_q),
    .cfg_i      (cfg_q),
    .status_i   (status_q),
    .div_used_i (div_used_q),
    .quot_i     (quot),
    .held_i     (held_q),
    .result_o   (result),
    .held_o     (held_next)
  );

  // Result may enter the output register once it is free or being taken
  assign load = (state_q == S_FIN) && (!out_valid_q || out_ch.ready);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = div_in ? S_DIV : S_FIN;
      S_DIV:  if (div_done) state_d = S_FIN;
      S_FIN:  if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      held_q.charger <= CHG_UNKNOWN;
      held_q.battery <= BAT_UNKNOWN;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        held_q      <= held_next;
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= result;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_data_q;

  // Held states never take an error code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q.charger != CHG_ERROR && held_q.battery != BAT_ERROR)
    else $error("held state holds an error code");

  // An invalid sample leaves the held states untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !result.sample_valid |=> $stable(held_q))
    else $error("held state changed on an invalid sample");

  // Divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider done outside the divide state");

  // Current is reported only for a measured status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && result.current_status != ST_MEASURED |-> result.current_ma == '0)
    else $error("current reported with a non-measured status");

endmodule

>>> sv/cbse_divider.sv
// ----------------------------------------------------------------------------
// cbse_divider: serial restoring divider
// One quotient bit per cycle; quotient stays valid after done until next start.
// ----------------------------------------------------------------------------
module cbse_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cbse_pkg::NUM_W-1:0]    num_i,
  input  logic [cbse_pkg::RES_BITS-1:0] div_i,
  output logic                          done_o,
  output logic [cbse_pkg::NUM_W-1:0]    quot_o
);
  import cbse_pkg::*;

  logic [NUM_W-1:0]    num_q;
  logic [RES_BITS-1:0] div_q;
  logic [RES_BITS-1:0] rem_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [RES_BITS:0]   shifted;
  logic [RES_BITS:0]   diff;
  logic                ge;

  // Trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};

  // Control: iteration count and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: numerator register turns into the quotient as bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      div_q <= div_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[RES_BITS-1:0] : shifted[RES_BITS-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

>>> sv/cbse_eval.sv
// ----------------------------------------------------------------------------
// cbse_eval: current clamp and charger / battery classification
// Builds the result item and the next held states from a finished item.
// ----------------------------------------------------------------------------
module cbse_eval (
  input  cbse_pkg::in_item_t         item_i,
  input  cbse_pkg::cfg_t             cfg_i,
  input  logic [1:0]                 status_i,
  input  logic                       div_used_i,
  input  logic [cbse_pkg::NUM_W-1:0] quot_i,
  input  cbse_pkg::held_t            held_i,
  output cbse_pkg::out_item_t        result_o,
  output cbse_pkg::held_t            held_o
);
  import cbse_pkg::*;

  logic [CUR_BITS-1:0] cur;
  logic                valid;
  logic                full;
  logic [2:0]          chg;
  logic [2:0]          bat;

  // Floor of 1 mA, saturation at full scale
  always_comb begin
    if (!div_used_i) begin
      cur = '0;
    end else if (quot_i[NUM_W-1:CUR_BITS] != '0) begin
      cur = '1;
    end else if (quot_i == '0) begin
      cur = CUR_BITS'(1);
    end else begin
      cur = quot_i[CUR_BITS-1:0];
    end
  end

  assign valid = item_i.supply_ok && (status_i != ST_INVALID);
  assign full  = item_i.supply_mv >= cfg_i.recharge_min_mv;

  // Charger state from program voltage window and supply
  always_comb begin
    if (status_i == ST_UNKNOWN) begin
      chg = CHG_UNKNOWN;
    end else if (item_i.prog_mv >= cfg_i.prog_cc_min_mv) begin
      chg = (item_i.supply_mv >= cfg_i.full_supply_min_mv) ? CHG_UNKNOWN : CHG_CC;
    end else if (item_i.prog_mv >= cfg_i.prog_cv_min_mv) begin
      chg = (item_i.supply_mv <= cfg_i.recharge_min_mv) ? CHG_UNKNOWN : CHG_CV;
    end else if (full) begin
      chg = CHG_FLOAT;
    end else if (cur == '0) begin
      chg = CHG_OFF;
    end else begin
      chg = CHG_UNKNOWN;
    end
  end

  // Battery state follows the charger state
  always_comb begin
    case (chg) inside
      CHG_ERROR:      bat = BAT_ERROR;
      CHG_CC, CHG_CV: bat = BAT_CHARGING;
      default: begin
        if (chg == CHG_FLOAT || full) begin
          bat = BAT_FULL;
        end else if (item_i.supply_mv < cfg_i.empty_supply_min_mv) begin
          bat = BAT_EMPTY;
        end else if (chg == CHG_OFF) begin
          bat = BAT_IDLE;
        end else begin
          bat = BAT_UNKNOWN;
        end
      end
    endcase
  end

  // Held states move only on a fully valid sample
  always_comb begin
    held_o.charger = valid ? chg : held_i.charger;
    held_o.battery = valid ? bat : held_i.battery;
  end

  always_comb begin
    result_o.sample_valid   = valid;
    result_o.current_ma     = (status_i == ST_MEASURED) ? cur : '0;
    result_o.current_status = status_i;
    result_o.charger_state  = held_o.charger;
    result_o.battery_state  = held_o.battery;
    result_o.battery_low    = !item_i.supply_ok ||
                              (item_i.supply_mv < cfg_i.empty_supply_min_mv);
    result_o.battery_full   = item_i.supply_ok && full;
  end

endmodule
